>>> design/egh_filter_bit_positions_defines.svh
// assertion macros shared by the checker
`ifndef EGH_FILTER_BIT_POSITIONS_DEFINES_SVH
`define EGH_FILTER_BIT_POSITIONS_DEFINES_SVH

// property checked only outside reset
`define EGH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define EGH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/egh_pkg.sv
package egh_pkg;

   localparam int TABLE_PRIMES = 32;
   localparam int RES_W        = 8;
   localparam int OFFSET_W     = 11;
   localparam int POS_W        = 9;
   localparam int SLOT_W       = 4;
   localparam int COUNT_W      = 5;
   localparam int IDX_LIMIT    = 16;

   typedef logic [RES_W-1:0]    residue_type;
   typedef logic [OFFSET_W-1:0] offset_type;

   localparam residue_type PRIME_TABLE [TABLE_PRIMES] = '{
      8'd2,   8'd3,   8'd5,   8'd7,   8'd11,  8'd13,  8'd17,  8'd19,
      8'd23,  8'd29,  8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,
      8'd59,  8'd61,  8'd67,  8'd71,  8'd73,  8'd79,  8'd83,  8'd89,
      8'd97,  8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131
   };

   // start of each prime's column block
   localparam offset_type OFFSET_TABLE [TABLE_PRIMES] = '{
      11'd0,    11'd2,    11'd5,    11'd10,   11'd17,   11'd28,   11'd41,   11'd58,
      11'd77,   11'd100,  11'd129,  11'd160,  11'd197,  11'd238,  11'd281,  11'd328,
      11'd381,  11'd440,  11'd501,  11'd568,  11'd639,  11'd712,  11'd791,  11'd874,
      11'd963,  11'd1060, 11'd1161, 11'd1264, 11'd1371, 11'd1480, 11'd1593, 11'd1720
   };

endpackage

>>> design/egh_cell.sv
module egh_cell #(
   parameter int MAX_PRIMES = 16,
   parameter int IDX_W      = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      advance,
   input  logic                                      in_valid,
   input  logic [IDX_W-1:0]                          in_index,
   input  egh_pkg::residue_type [MAX_PRIMES-1:0]     in_residue,
   output logic                                      out_valid,
   output logic [IDX_W-1:0]                          out_index,
   output egh_pkg::residue_type [MAX_PRIMES-1:0]     out_residue
);

   logic                                  valid_ff;
   logic [IDX_W-1:0]                      index_ff;
   logic [IDX_W-1:0]                      index_in;
   egh_pkg::residue_type [MAX_PRIMES-1:0] residue_ff;
   egh_pkg::residue_type [MAX_PRIMES-1:0] residue_in;
   logic [egh_pkg::RES_W:0]               trial [MAX_PRIMES];

   // one index bit a cell, msb first: r = (2r + b) mod p
   always_comb begin
      index_in = in_index << 1;
      for (int p = 0; p < MAX_PRIMES; p++) begin
         trial[p] = {in_residue[p], in_index[IDX_W-1]};
         if (trial[p] >= {1'b0, egh_pkg::PRIME_TABLE[p]}) begin
            residue_in[p] = egh_pkg::RES_W'(trial[p] - {1'b0, egh_pkg::PRIME_TABLE[p]});
         end else begin
            residue_in[p] = egh_pkg::RES_W'(trial[p]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         index_ff   <= index_in;
         residue_ff <= residue_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_index   = index_ff;
   assign out_residue = residue_ff;

endmodule

>>> design/egh_emit.sv
module egh_emit #(
   parameter int MAX_PRIMES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [egh_pkg::COUNT_W-1:0]           prime_count,
   input  logic                                  tail_valid,
   input  egh_pkg::residue_type [MAX_PRIMES-1:0] tail_residue,
   output logic                                  tail_take,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [egh_pkg::POS_W-1:0]             rsp_bit_position,
   output logic [egh_pkg::SLOT_W-1:0]            rsp_prime_slot,
   output logic                                  rsp_last_position
);

   localparam int K_W = egh_pkg::COUNT_W + 1;

   logic                                  row_valid_ff, row_valid_in;
   logic [egh_pkg::COUNT_W-1:0]           slot_ff, slot_in;
   egh_pkg::residue_type [MAX_PRIMES-1:0] residue_ff, residue_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [egh_pkg::POS_W-1:0]             position_ff, position_in;
   logic [egh_pkg::SLOT_W-1:0]            slot_out_ff;
   logic                                  last_ff;

   logic [K_W-1:0] count_ext;
   logic [K_W-1:0] row_len;
   logic           issue;
   logic           is_last;
   logic           row_free;

   always_comb begin
      count_ext = {1'b0, prime_count};
      row_len   = (count_ext > K_W'(MAX_PRIMES)) ? K_W'(MAX_PRIMES) : count_ext;
      issue     = row_valid_ff && (!rsp_valid_ff || !rsp_stall);
      is_last   = (K_W'(slot_ff) + K_W'(1)) == row_len;
      row_free  = !row_valid_ff || (issue && is_last);
      // an empty row is dropped as soon as it reaches the end of the chain
      tail_take = tail_valid && ((row_len == '0) || row_free);
      position_in = egh_pkg::POS_W'({1'b0, egh_pkg::OFFSET_TABLE[slot_ff]}
                                    + egh_pkg::OFFSET_W'(residue_ff[0]));
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      slot_in      = slot_ff;
      residue_in   = residue_ff;
      if (issue) begin
         slot_in = slot_ff + 1'b1;
         for (int i = 0; i < MAX_PRIMES - 1; i++) begin
            residue_in[i] = residue_ff[i+1];
         end
         if (is_last) begin
            row_valid_in = 1'b0;
         end
      end
      if (tail_take) begin
         row_valid_in = (row_len != '0);
         slot_in      = '0;
         residue_in   = tail_residue;
      end
      if (issue) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      residue_ff <= residue_in;
      if (issue) begin
         position_ff <= position_in;
         slot_out_ff <= egh_pkg::SLOT_W'(slot_ff);
         last_ff     <= is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bit_position  = position_ff;
   assign rsp_prime_slot    = slot_out_ff;
   assign rsp_last_position = last_ff;

endmodule

>>> design/egh_filter_bit_positions.sv
// EGH filter row generator
// req channel: one element index per transfer (req_valid / req_stall).
// rsp channel: the sparse filter row of that element, one set bit position per
//   transfer, in prime order; rsp_last_position marks the final one.
// csr channel: writes prime_count, the number k of leading primes used (values
//   above MAX_PRIMES act as MAX_PRIMES, zero gives an empty row). csr_ready is
//   always high; write only while no element is in flight.
// cell row: the index walks a row of min(INDEX_BITS, 16) cells, one index bit
//   each, reducing it modulo every prime; a row's first position then passes the
//   emit stage's row register and its output register before it transfers.
// output: the output stage gives one position a cycle while rsp_stall is low;
//   a new index enters the cell row while earlier rows drain.
// reset: clears the cell row, the output stage and sets prime_count to 16.
// rsp_stall holds the output register and the row being emitted; while the element
//   at the end of the cell row cannot hand over, the whole row holds and req_stall
//   is high.
module egh_filter_bit_positions #(
   parameter int MAX_PRIMES = 16,
   parameter int INDEX_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [INDEX_BITS-1:0]              req_element_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [egh_pkg::POS_W-1:0]          rsp_bit_position,
   output logic [egh_pkg::SLOT_W-1:0]         rsp_prime_slot,
   output logic                               rsp_last_position,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [egh_pkg::COUNT_W-1:0]        csr_prime_count
);

   localparam int USE_BITS =
      (INDEX_BITS < egh_pkg::IDX_LIMIT) ? INDEX_BITS : egh_pkg::IDX_LIMIT;

   logic [egh_pkg::COUNT_W-1:0]           prime_count_ff;
   logic                                  advance;
   logic                                  tail_take;
   logic                                  chain_valid [USE_BITS+1];
   logic [USE_BITS-1:0]                   chain_index [USE_BITS];
   egh_pkg::residue_type [MAX_PRIMES-1:0] chain_residue [USE_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_count_ff <= egh_pkg::COUNT_W'(16);
      end else if (csr_valid) begin
         prime_count_ff <= csr_prime_count;
      end
   end

   assign csr_ready = 1'b1;

   // whole row moves together; it holds only when the tail cannot hand over
   assign advance   = !chain_valid[USE_BITS] || tail_take;
   assign req_stall = !advance;

   assign chain_valid[0]   = req_valid;
   assign chain_index[0]   = req_element_index[USE_BITS-1:0];
   assign chain_residue[0] = '0;

   for (genvar i = 0; i < USE_BITS; i++) begin : g_cell
      if (i == USE_BITS - 1) begin : g_tail
         egh_cell #(
            .MAX_PRIMES (MAX_PRIMES),
            .IDX_W      (USE_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .advance     (advance),
            .in_valid    (chain_valid[i]),
            .in_index    (chain_index[i]),
            .in_residue  (chain_residue[i]),
            .out_valid   (chain_valid[i+1]),
            .out_index   (),
            .out_residue (chain_residue[i+1])
         );
      end else begin : g_body
         egh_cell #(
            .MAX_PRIMES (MAX_PRIMES),
            .IDX_W      (USE_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .advance     (advance),
            .in_valid    (chain_valid[i]),
            .in_index    (chain_index[i]),
            .in_residue  (chain_residue[i]),
            .out_valid   (chain_valid[i+1]),
            .out_index   (chain_index[i+1]),
            .out_residue (chain_residue[i+1])
         );
      end
   end

   egh_emit #(
      .MAX_PRIMES (MAX_PRIMES)
   ) u_emit (
      .clock             (clock),
      .reset             (reset),
      .prime_count       (prime_count_ff),
      .tail_valid        (chain_valid[USE_BITS]),
      .tail_residue      (chain_residue[USE_BITS]),
      .tail_take         (tail_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bit_position  (rsp_bit_position),
      .rsp_prime_slot    (rsp_prime_slot),
      .rsp_last_position (rsp_last_position)
   );

endmodule

>>> design/egh_checker.sv
`include "egh_filter_bit_positions_defines.svh"

module egh_checker #(
   parameter int INDEX_BITS = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [INDEX_BITS-1:0]       req_element_index,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [egh_pkg::POS_W-1:0]   rsp_bit_position,
   input logic [egh_pkg::SLOT_W-1:0]  rsp_prime_slot,
   input logic                        rsp_last_position
);

   // a stalled request keeps its index
   `EGH_ASSERT(a_req_hold, clock, reset,
      req_valid && req_stall |=> req_valid && $stable(req_element_index),
      "request changed while stalled")

   // a stalled result keeps its value
   `EGH_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bit_position)
         && $stable(rsp_prime_slot) && $stable(rsp_last_position),
      "result changed while stalled")

   `EGH_ASSERT_ALWAYS(a_reset_quiet, clock,
      reset |=> !rsp_valid,
      "result valid straight after reset")

   // within a row the slots run up by one
   `EGH_ASSERT(a_slot_step, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_position |=>
         !rsp_valid || rsp_prime_slot == egh_pkg::SLOT_W'($past(rsp_prime_slot) + 1'b1),
      "prime slot out of order within a row")

   // a new row starts at slot zero
   `EGH_ASSERT(a_row_start, clock, reset,
      rsp_valid && !rsp_stall && rsp_last_position |=> !rsp_valid || rsp_prime_slot == '0,
      "row did not start at slot zero")

endmodule

bind egh_filter_bit_positions egh_checker #(
   .INDEX_BITS (INDEX_BITS)
) u_egh_checker (.*);
